FILE: hdl/pipc_pkg.sv
// ---------------------------------------------------------------------------
// pipc_pkg: shared types and constants of the point-in-polygon classifier
// Field widths, register indexes, request kinds and result codes.
// ---------------------------------------------------------------------------
package pipc_pkg;

  // default vertex store depth
  localparam int MAX_VERTICES_DEF = 64;

  // field widths
  localparam int COORD_W = 31;
  localparam int DIFF_W  = 32;
  localparam int PROD_W  = 64;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int LOC_W   = 2;

  // stream and configuration port widths
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 31;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  // request kinds (tuser)
  localparam logic REQ_VERTEX = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RAY_END_X    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RAY_END_Y    = 2'd2;

  // reset values
  localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = 7'd3;
  localparam coord_t           RAY_END_RESET      = 31'sd1000000001;

  // result codes
  localparam logic [LOC_W-1:0] LOC_OUTSIDE  = 2'd0;
  localparam logic [LOC_W-1:0] LOC_INSIDE   = 2'd1;
  localparam logic [LOC_W-1:0] LOC_BOUNDARY = 2'd2;

endpackage

FILE: hdl/point_in_polygon_classifier_top.sv
// ---------------------------------------------------------------------------
// point_in_polygon_classifier_top: ray-casting point-in-polygon classifier
// Stores polygon vertices and classifies query points as outside, inside
// or on the boundary, one polygon edge per cycle through a shared pipeline.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser selects the request. A vertex write stores
//   (coord_x, coord_y) at vertex_index and gives no result.
//   A query runs every edge, closing edge included, through one shared
//   edge test unit (differences, six products, three sums, decision),
//   fed by one read port of the vertex store: one read per cycle,
//   vertex 0 read again at the end to close the polygon.
//   A query with n vertices in use makes n + 1 store reads, passes them
//   through the unit stages and loads its result; with none in use it
//   makes no read. in_tready is low for that time, so the next item is
//   taken only once the result of the query has been loaded.
//   Output stream: one 2-bit location per query in a result register; a
//   stalled receiver only holds off the end of a later query, new items
//   are taken while a result waits.
//   Configuration: cfg_wr_en writes vertex_count, ray_end_x or ray_end_y;
//   the user must write only while idle; the block does not enforce it.
//   Reset presets control and config; the vertex store is never reset.
// ---------------------------------------------------------------------------
module point_in_polygon_classifier_top #(
  parameter int MAX_VERTICES = pipc_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [5:0] vertex_index, [36:6] coord_x, [67:37] coord_y, [71:68] zero
  input  logic [pipc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] req_type
  input  logic                               in_tuser,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] location, [7:2] zero
  output logic [pipc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // configuration write port
  input  logic                               cfg_wr_en,
  input  logic [pipc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pipc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pipc_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = AW + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // input field unpacking
  logic [IDX_W-1:0] in_idx;
  coord_t           in_x;
  coord_t           in_y;
  assign in_idx = in_tdata[IDX_W-1:0];
  assign in_x   = in_tdata[IDX_W+COORD_W-1:IDX_W];
  assign in_y   = in_tdata[IDX_W+2*COORD_W-1:IDX_W+COORD_W];

  logic in_acc;
  logic vert_wr;
  logic query_acc;
  assign in_acc    = in_tvalid && in_tready;
  assign vert_wr   = in_acc && (in_tuser == REQ_VERTEX) &&
                     (32'(in_idx) < MAX_VERTICES);
  assign query_acc = in_acc && (in_tuser == REQ_QUERY);

  // configuration registers
  logic [CNT_W-1:0] count_r;
  coord_t           ray_x_r;
  coord_t           ray_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= VERTEX_COUNT_RESET;
      ray_x_r <= RAY_END_RESET;
      ray_y_r <= RAY_END_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_VERTEX_COUNT: count_r <= cfg_wdata[CNT_W-1:0];
        REG_RAY_END_X:    ray_x_r <= cfg_wdata;
        REG_RAY_END_Y:    ray_y_r <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // edges in use, saturated to the store depth
  logic [CW-1:0] n_eff;
  assign n_eff = (32'(count_r) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(count_r);

  // sequencer
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] n_r;
  logic          issue;
  logic [AW-1:0] rd_addr;
  logic          pipe_busy;
  logic          out_free;
  logic          res_load;

  logic rd_vld_r, rd_edge_r;
  logic d_vld_r, p_vld_r, s_vld_r;

  assign issue     = (state_r == ST_RUN);
  assign rd_addr   = (k_r == n_r) ? '0 : k_r[AW-1:0];
  assign pipe_busy = rd_vld_r || d_vld_r || p_vld_r || s_vld_r;
  assign out_free  = !out_tvalid || out_tready;
  assign res_load  = (state_r == ST_DRAIN) && !pipe_busy && out_free;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (query_acc) begin
          k_nxt     = '0;
          state_nxt = (n_eff == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        k_nxt = k_r + CW'(1);
        if (k_r == n_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (res_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  // query operands, captured at acceptance
  coord_t cx_r, cy_r;
  diff_t  dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (query_acc) begin
      n_r  <= n_eff;
      cx_r <= in_x;
      cy_r <= in_y;
      dx_r <= DIFF_W'(ray_x_r) - DIFF_W'(in_x);
      dy_r <= DIFF_W'(ray_y_r) - DIFF_W'(in_y);
    end
  end

  // vertex store, one write port and one registered read port
  coord_t mem_x [MAX_VERTICES];
  coord_t mem_y [MAX_VERTICES];
  coord_t rd_x_r, rd_y_r;

  always_ff @(posedge clk) begin
    if (vert_wr) begin
      mem_x[AW'(in_idx)] <= in_x;
      mem_y[AW'(in_idx)] <= in_y;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  // pipeline valids; first read of a query only primes the start vertex
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      rd_edge_r <= 1'b0;
      d_vld_r   <= 1'b0;
      p_vld_r   <= 1'b0;
      s_vld_r   <= 1'b0;
    end else begin
      rd_vld_r  <= issue;
      rd_edge_r <= issue && (k_r != '0);
      d_vld_r   <= rd_vld_r && rd_edge_r;
      p_vld_r   <= d_vld_r;
      s_vld_r   <= p_vld_r;
    end
  end

  // stage D: edge and point differences, bounding box test
  coord_t a_x_r, a_y_r;
  diff_t  ex_r, ey_r, rx_r, ry_r;
  logic   d_bb_r;

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      a_x_r  <= rd_x_r;
      a_y_r  <= rd_y_r;
      ex_r   <= DIFF_W'(rd_x_r) - DIFF_W'(a_x_r);
      ey_r   <= DIFF_W'(rd_y_r) - DIFF_W'(a_y_r);
      rx_r   <= DIFF_W'(cx_r) - DIFF_W'(a_x_r);
      ry_r   <= DIFF_W'(cy_r) - DIFF_W'(a_y_r);
      d_bb_r <= ((a_x_r <= cx_r) || (rd_x_r <= cx_r)) &&
                ((cx_r <= a_x_r) || (cx_r <= rd_x_r)) &&
                ((a_y_r <= cy_r) || (rd_y_r <= cy_r)) &&
                ((cy_r <= a_y_r) || (cy_r <= rd_y_r));
    end
  end

  // stage P: six products, each one 32x32 multiplier
  prod_t m_r [6];
  logic  p_bb_r;

  always_ff @(posedge clk) begin
    m_r[0] <= ex_r * dy_r;
    m_r[1] <= ey_r * dx_r;
    m_r[2] <= rx_r * ey_r;
    m_r[3] <= ry_r * ex_r;
    m_r[4] <= rx_r * dy_r;
    m_r[5] <= ry_r * dx_r;
    p_bb_r <= d_bb_r;
  end

  // stage S: scaled area and the two intersection parameters
  prod_t area_r, u_r, t_r;
  logic  s_bb_r;

  always_ff @(posedge clk) begin
    area_r <= m_r[0] - m_r[1];
    u_r    <= m_r[2] - m_r[3];
    t_r    <= m_r[4] - m_r[5];
    s_bb_r <= p_bb_r;
  end

  // decision: compare with sign instead of negating for a negative area
  logic hit, on_edge, crossing;

  always_comb begin
    if (area_r[PROD_W-1])
      hit = (u_r <= 0) && (u_r >= area_r) && (t_r <= 0) && (t_r >= area_r);
    else
      hit = (u_r >= 0) && (u_r <= area_r) && (t_r >= 0) && (t_r <= area_r);
    if (area_r == '0) begin
      on_edge  = (u_r == '0) && s_bb_r;
      crossing = 1'b0;
    end else begin
      on_edge  = hit && (u_r == '0);
      crossing = hit && (u_r != '0);
    end
  end

  // boundary flag and crossing parity
  logic bnd_r, par_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_r <= 1'b0;
      par_r <= 1'b0;
    end else if (query_acc) begin
      bnd_r <= 1'b0;
      par_r <= 1'b0;
    end else if (s_vld_r) begin
      bnd_r <= bnd_r || on_edge;
      par_r <= par_r ^ crossing;
    end
  end

  // result register
  logic             out_vld_r;
  logic [LOC_W-1:0] out_loc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load)
      out_loc_r <= bnd_r ? LOC_BOUNDARY : (par_r ? LOC_INSIDE : LOC_OUTSIDE);
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-LOC_W){1'b0}}, out_loc_r};

  // checks
  a_loc_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[LOC_W-1:0] != 2'd3))
    else $error("invalid location code on result");

  a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (k_r <= n_r))
    else $error("edge sequencer ran past vertex count");

  a_stage_follow: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld_r |-> $past(rd_vld_r && rd_edge_r))
    else $error("difference stage valid without an edge read");

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> (!bnd_r && !par_r))
    else $error("accumulators not cleared at query start");

endmodule

FILE: tb/sv/point_in_polygon_classifier_top_test.sv
// ---------------------------------------------------------------------------
// point_in_polygon_classifier_top_test: self-checking bench for the classifier
// Loads polygons through the input stream and classifies query points
// against them under several vertex counts and ray end points. A scoreboard
// recomputes every location from its own copy of the vertex store and
// compares it with each result, while both stream sides idle and stall
// at random.
// ---------------------------------------------------------------------------
module point_in_polygon_classifier_top_test;
  import pipc_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int ITEM_TARGET  = 850;
  localparam int DRAIN_CYCLES = 96;      // drain wait after the last result, with margin for the longest query
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;
  localparam int NVTX         = MAX_VERTICES_DEF;

  localparam coord_t C_MIN = 31'sh4000_0000;  // most negative coordinate
  localparam coord_t C_MAX = 31'sh3FFF_FFFF;  // most positive coordinate

  typedef enum {EDGE_MISS, EDGE_CROSS, EDGE_ON} edge_hit_t;

  // -------------------------------------------------------------------------
  // Scoreboard: shadow vertex store, registers and expected locations
  // -------------------------------------------------------------------------
  class location_scoreboard;
    coord_t               vtx_x [NVTX];
    coord_t               vtx_y [NVTX];
    logic [CNT_W-1:0]     vertex_count;
    coord_t               ray_x;
    coord_t               ray_y;
    logic [LOC_W-1:0]     expected_locations[$];
    int unsigned          location_tally[3];
    int unsigned          vertex_writes;
    int unsigned          results_checked;
    int unsigned          errors;

    function new();
      vertex_count = VERTEX_COUNT_RESET;
      ray_x        = RAY_END_RESET;
      ray_y        = RAY_END_RESET;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_VERTEX_COUNT: vertex_count = value[CNT_W-1:0];
        REG_RAY_END_X:    ray_x = coord_t'(value);
        REG_RAY_END_Y:    ray_y = coord_t'(value);
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_locations.size();
    endfunction

    // one edge A..B against the segment from point P to the ray end
    function edge_hit_t edge_hit(longint ax, longint ay, longint bx, longint by,
                                 longint px, longint py);
      longint ex, ey, dx, dy, rx, ry, area, u, t;
      ex   = bx - ax;
      ey   = by - ay;
      dx   = ray_x - px;
      dy   = ray_y - py;
      rx   = px - ax;
      ry   = py - ay;
      area = ex * dy - ey * dx;
      u    = rx * ey - ry * ex;
      // parallel edge: only a point lying on the closed segment matters
      if (area == 0) begin
        if (u == 0 && px >= ((ax < bx) ? ax : bx) && px <= ((ax > bx) ? ax : bx) &&
            py >= ((ay < by) ? ay : by) && py <= ((ay > by) ? ay : by))
          return EDGE_ON;
        return EDGE_MISS;
      end
      t = rx * dy - ry * dx;
      if (area < 0) begin
        area = -area;
        u    = -u;
        t    = -t;
      end
      // both ends inclusive; u == 0 puts the point on the edge line
      if (u >= 0 && u <= area && t >= 0 && t <= area)
        return (u == 0) ? EDGE_ON : EDGE_CROSS;
      return EDGE_MISS;
    endfunction

    // crossing parity over all edges, closing edge included
    function logic [LOC_W-1:0] locate_point(coord_t px, coord_t py);
      int        used, j, nxt;
      bit        odd;
      edge_hit_t hit;
      used = (vertex_count > NVTX) ? NVTX : vertex_count;
      odd  = 1'b0;
      for (j = 0; j < used; j++) begin
        nxt = (j + 1 == used) ? 0 : j + 1;
        hit = edge_hit(vtx_x[j], vtx_y[j], vtx_x[nxt], vtx_y[nxt], px, py);
        if (hit == EDGE_ON)
          return LOC_BOUNDARY;
        if (hit == EDGE_CROSS)
          odd = !odd;
      end
      return odd ? LOC_INSIDE : LOC_OUTSIDE;
    endfunction

    function void note_request(logic kind, logic [IDX_W-1:0] idx, coord_t x, coord_t y);
      if (kind == REQ_VERTEX) begin
        if (idx < NVTX) begin
          vtx_x[idx] = x;
          vtx_y[idx] = y;
        end
        vertex_writes++;
      end else begin
        expected_locations.push_back(locate_point(x, y));
      end
    endfunction

    function void check_location(logic [LOC_W-1:0] got);
      logic [LOC_W-1:0] want;
      if (expected_locations.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: location %0d arrived with no query pending", got);
        return;
      end
      want = expected_locations.pop_front();
      results_checked++;
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: result %0d location expected %0d, actual %0d",
                   results_checked, want, got);
      end else begin
        location_tally[want]++;
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Signals and DUT
  // -------------------------------------------------------------------------
  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [5:0] vertex_index, [36:6] coord_x, [67:37] coord_y, [71:68] zero
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  // [0] req_type
  logic                   in_tuser  = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [1:0] location, [7:2] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  location_scoreboard locations = new();

  coord_t shadow_x [NVTX];
  coord_t shadow_y [NVTX];
  int     items_sent       = 0;
  int     settings_applied = 0;
  int     cycle_count      = 0;
  bit     tx_burst         = 1'b0;
  bit     rx_burst         = 1'b0;

  point_in_polygon_classifier_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // -------------------------------------------------------------------------
  // Monitors: every transaction on either stream goes to the scoreboard
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      locations.note_request(in_tuser, in_tdata[5:0], in_tdata[36:6], in_tdata[67:37]);
    if (rst_n && out_tvalid && out_tready)
      locations.check_location(out_tdata[LOC_W-1:0]);
  end

  // watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results still expected",
             cycle_count, locations.pending());
    $display("CHECKS FAILED");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Helpers
  // -------------------------------------------------------------------------
  // idle cycles before a transaction; occasionally flips into a no-idle stretch
  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0)
      burst = !burst;
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  // small grid for many edge, vertex and parallel hits, else the full range
  function automatic coord_t pick_coord(bit on_grid);
    if (on_grid)
      return coord_t'(int'($urandom_range(0, 24)) - 12);
    return coord_t'($urandom());
  endfunction

  task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
                           input coord_t x, input coord_t y);
    int gap;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, y, x, idx};
    do @(posedge clk); while (!in_tready);
    if (kind == REQ_VERTEX) begin
      shadow_x[idx] = x;
      shadow_y[idx] = y;
    end
    items_sent++;
  endtask

  // stop sending, wait for all results, then let a last query drain
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (locations.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    locations.set_register(idx, value);
  endtask

  task automatic apply_settings(input logic [CNT_W-1:0] count, input coord_t rx,
                                input coord_t ry);
    settle();
    write_register(REG_VERTEX_COUNT, CFG_DATA_W'(count));
    write_register(REG_RAY_END_X, rx);
    write_register(REG_RAY_END_Y, ry);
    cfg_wr_en <= 1'b0;
    settings_applied++;
  endtask

  // -------------------------------------------------------------------------
  // Result side: random stall before each result
  // -------------------------------------------------------------------------
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = draw_gap(rx_burst);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    int     i, j, k, count, used, queries, phase, sel;
    bit     on_grid;
    coord_t rx, ry;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: big triangle on the coordinate extremes
    send_item(REQ_VERTEX, 0, C_MIN, C_MIN);
    send_item(REQ_VERTEX, 1, C_MAX, C_MIN);
    send_item(REQ_VERTEX, 2, C_MIN, C_MAX);
    send_item(REQ_VERTEX, 63, C_MAX, C_MAX);
    send_item(REQ_QUERY, 0, -1000, -1000);
    send_item(REQ_QUERY, 0, C_MIN, C_MIN);                  // on a vertex
    send_item(REQ_QUERY, 0, 0, C_MIN);                      // on an edge
    send_item(REQ_QUERY, 63, RAY_END_RESET, RAY_END_RESET); // point at ray end

    // no vertices in use
    apply_settings(0, -RAY_END_RESET, C_MIN);
    send_item(REQ_QUERY, 0, 0, 0);

    // single vertex: degenerate edge, parallel to any ray
    apply_settings(1, C_MAX, -RAY_END_RESET);
    send_item(REQ_VERTEX, 0, 7, -3);
    send_item(REQ_QUERY, 0, 7, -3);
    send_item(REQ_QUERY, 0, 0, 0);

    // two vertices: segment crossed twice by a horizontal ray
    apply_settings(2, C_MAX, 0);
    send_item(REQ_VERTEX, 0, 5, -5);
    send_item(REQ_VERTEX, 1, 5, 5);
    send_item(REQ_QUERY, 0, 0, 0);
    send_item(REQ_QUERY, 0, 5, 0);
    send_item(REQ_QUERY, 0, 5, -5);

    // square with a ray along its bottom edge
    apply_settings(4, RAY_END_RESET, 0);
    send_item(REQ_VERTEX, 0, 0, 0);
    send_item(REQ_VERTEX, 1, 10, 0);
    send_item(REQ_VERTEX, 2, 10, 10);
    send_item(REQ_VERTEX, 3, 0, 10);
    send_item(REQ_QUERY, 0, 3, 0);              // on the parallel edge
    send_item(REQ_QUERY, 0, 5, 5);
    send_item(REQ_QUERY, 0, -5, 0);             // ray through two vertices
    send_item(REQ_QUERY, 0, RAY_END_RESET, 0);

    // random phases: new settings, full polygon load, then mixed traffic
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 19);
      if (phase == 0)
        count = 127;
      else if (phase == 1)
        count = 64;
      else if (sel == 0)
        count = $urandom_range(0, 2);
      else if (sel == 1)
        count = $urandom_range(65, 127);
      else if (sel <= 3)
        count = $urandom_range(13, 64);
      else
        count = $urandom_range(3, 12);
      used    = (count > NVTX) ? NVTX : count;
      on_grid = ($urandom_range(0, 3) != 0);

      case ($urandom_range(0, 3))
        0: begin
          rx = $urandom_range(0, 1) ? RAY_END_RESET : -RAY_END_RESET;
          ry = $urandom_range(0, 1) ? RAY_END_RESET : -RAY_END_RESET;
        end
        1: begin
          rx = coord_t'($urandom());
          ry = coord_t'($urandom());
        end
        2: begin
          rx = pick_coord(on_grid);
          ry = pick_coord(on_grid);
        end
        default: begin
          rx = RAY_END_RESET;
          ry = RAY_END_RESET;
        end
      endcase
      apply_settings(CNT_W'(count), rx, ry);

      for (i = 0; i < used; i++)
        send_item(REQ_VERTEX, IDX_W'(i), pick_coord(on_grid), pick_coord(on_grid));

      queries = $urandom_range(4, 14);
      for (i = 0; i < queries; i++) begin
        j = (used == 0) ? 0 : $urandom_range(0, used - 1);
        k = (j + 1 >= used) ? 0 : j + 1;
        case ($urandom_range(0, 9))
          // rewrite any slot mid-stream
          0: send_item(REQ_VERTEX, IDX_W'($urandom_range(0, 63)), pick_coord(on_grid),
                       pick_coord(on_grid));
          1: send_item(REQ_QUERY, IDX_W'($urandom_range(0, 63)), shadow_x[j],
                       shadow_y[j]);
          2: send_item(REQ_QUERY, IDX_W'($urandom_range(0, 63)),
                       coord_t'((longint'(shadow_x[j]) + shadow_x[k]) / 2),
                       coord_t'((longint'(shadow_y[j]) + shadow_y[k]) / 2));
          3: send_item(REQ_QUERY, IDX_W'($urandom_range(0, 63)), rx, ry);
          4: send_item(REQ_QUERY, IDX_W'($urandom_range(0, 63)), coord_t'($urandom()),
                       coord_t'($urandom()));
          default: send_item(REQ_QUERY, IDX_W'($urandom_range(0, 63)),
                             pick_coord(on_grid), pick_coord(on_grid));
        endcase
      end
      phase++;
    end

    settle();

    $display("Run summary: %0d items (%0d vertex writes) over %0d register settings.",
             items_sent, locations.vertex_writes, settings_applied);
    $display("Locations checked: %0d outside, %0d inside, %0d boundary; %0d errors.",
             locations.location_tally[LOC_OUTSIDE], locations.location_tally[LOC_INSIDE],
             locations.location_tally[LOC_BOUNDARY], locations.errors);
    if (locations.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
hdl/pipc_pkg.sv
hdl/point_in_polygon_classifier_top.sv
tb/sv/point_in_polygon_classifier_top_test.sv
